FILE: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Word types, action and status codes, and cell command codes for the
// sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_BITS     = 27;
    localparam int IN_PAY_BITS  = 32;
    localparam int ACTION_BITS  = 2;
    localparam int STATUS_BITS  = 2;
    localparam int POS_BITS     = 6;
    localparam int COUNT_BITS   = 7;
    localparam int CELL_OP_BITS = 3;

    // actions
    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd2;

    // result status
    localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

    // commands broadcast to the cell chain
    localparam logic [CELL_OP_BITS-1:0] CELL_NOP = 3'd0;
    localparam logic [CELL_OP_BITS-1:0] CELL_CMP = 3'd1;
    localparam logic [CELL_OP_BITS-1:0] CELL_INS = 3'd2;
    localparam logic [CELL_OP_BITS-1:0] CELL_UPD = 3'd3;
    localparam logic [CELL_OP_BITS-1:0] CELL_DEL = 3'd4;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [KEY_BITS-1:0]    key;
        logic [IN_PAY_BITS-1:0] payload;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic [KEY_BITS-1:0]    key_out;
        logic [IN_PAY_BITS-1:0] payload_out;
        logic [COUNT_BITS-1:0]  count;
        logic                   is_empty;
        logic                   is_full;
    } t_out_word;

    typedef struct packed {
        logic [CELL_OP_BITS-1:0] op;
        logic [KEY_BITS-1:0]     key;
    } t_cell_ctl;

    // compare results held by a cell, plus its insert decision
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
        logic ins;
    } t_cell_flag;

endpackage

FILE: hdl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Sorted record table built as a chain of compare-and-shift cells with a
// small sequencer for binary search and result formatting.
// ----------------------------------------------------------------------------
// One word is worked on at a time. Every cell compares its key with the
// incoming key in S_CMP and registers its flags; an insert then shifts the
// chain in S_EXEC. Update and delete walk a binary search over the
// registered compare flags, one probe per cycle, up to clog2(CAPACITY)+1
// probes; a delete passes through S_READ before S_EXEC to pull the removed
// payload through a registered OR tree. The output register lets a new
// word be accepted while the last result still waits to be taken.
module sorted_key_table_top
    import skt_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int GRP = 8;
    localparam int NG  = (CAPACITY + GRP - 1) / GRP;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    t_in_word                r_in, n_in;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hip1, n_hip1;
    logic [IW-1:0]           r_slot, n_slot;
    t_out_word               r_res, n_res;
    t_out_word               r_out, n_out;
    logic                    r_out_valid, n_out_valid;
    logic [PAYLOAD_BITS-1:0] r_grp [NG];

    t_cell_ctl               w_ctl;
    logic [PAYLOAD_BITS-1:0] w_pay_in;
    logic [KEY_BITS-1:0]     w_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_pay [CAPACITY];
    t_cell_flag              w_flag [CAPACITY];
    logic [CAPACITY-1:0]     w_lt, w_eq, w_ins;
    logic [NG*GRP-1:0][PAYLOAD_BITS-1:0] w_msk;
    logic [PAYLOAD_BITS-1:0] w_grp [NG];
    logic [PAYLOAD_BITS-1:0] w_rd;
    logic [IW-1:0]           w_ins_pos;
    logic [CW:0]             w_sum;
    logic [IW-1:0]           w_mid;
    logic                    w_full;

    function automatic t_out_word make_res(
        input logic [STATUS_BITS-1:0]  st,
        input logic [IW-1:0]           pos,
        input logic [KEY_BITS-1:0]     k,
        input logic [PAYLOAD_BITS-1:0] p,
        input logic [CW-1:0]           cnt
    );
        t_out_word w;
        w.status      = st;
        w.position    = POS_BITS'(pos);
        w.key_out     = k;
        w.payload_out = IN_PAY_BITS'(p);
        w.count       = COUNT_BITS'(cnt);
        w.is_empty    = (cnt == '0);
        w.is_full     = (cnt == CW'(CAPACITY));
        return w;
    endfunction

    assign w_pay_in = PAYLOAD_BITS'(r_in.payload);

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                    w_bgt;
        logic [KEY_BITS-1:0]     w_bkey, w_akey;
        logic [PAYLOAD_BITS-1:0] w_bpay, w_apay;

        if (i == 0) begin : g_bot
            assign w_bgt  = 1'b0;
            assign w_bkey = '0;
            assign w_bpay = '0;
        end else begin : g_mid
            assign w_bgt  = w_flag[i-1].gt;
            assign w_bkey = w_key[i-1];
            assign w_bpay = w_pay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign w_akey = w_key[i];
            assign w_apay = w_pay[i];
        end else begin : g_low
            assign w_akey = w_key[i+1];
            assign w_apay = w_pay[i+1];
        end

        skt_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW),
            .PW  (PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pay       (w_pay_in),
            .i_slot      (r_slot),
            .i_count     (r_count),
            .i_below_gt  (w_bgt),
            .i_below_key (w_bkey),
            .i_below_pay (w_bpay),
            .i_above_key (w_akey),
            .i_above_pay (w_apay),
            .o_key       (w_key[i]),
            .o_pay       (w_pay[i]),
            .o_flag      (w_flag[i])
        );

        assign w_lt[i]  = w_flag[i].lt;
        assign w_eq[i]  = w_flag[i].eq;
        assign w_ins[i] = w_flag[i].ins;
        assign w_msk[i] = (r_slot == IW'(i)) ? w_pay[i] : '0;
    end

    for (genvar i = CAPACITY; i < NG * GRP; i++) begin : g_pad
        assign w_msk[i] = '0;
    end

    // read of the removed payload: groups registered, then a final OR
    for (genvar g = 0; g < NG; g++) begin : g_grp
        always_comb begin
            w_grp[g] = '0;
            for (int m = 0; m < GRP; m++) begin
                w_grp[g] = w_grp[g] | w_msk[g*GRP+m];
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_grp[g];
        end
    end

    always_comb begin
        w_rd = '0;
        for (int g = 0; g < NG; g++) begin
            w_rd = w_rd | r_grp[g];
        end
    end

    always_comb begin
        w_ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_ins[i]) begin
                w_ins_pos = w_ins_pos | IW'(i);
            end
        end
    end

    // probe sits at (lo + hi) / 2 with hi = hip1 - 1
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hip1} - (CW+1)'(1);
    assign w_mid  = IW'(w_sum >> 1);
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hip1      = r_hip1;
        n_slot      = r_slot;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_ctl.op    = CELL_NOP;
        w_ctl.key   = r_in.key;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.op = CELL_CMP;
                case (r_in.action)
                    ACT_INSERT: begin
                        if (w_full) begin
                            n_res   = make_res(ST_FULL, '0, r_in.key, w_pay_in, r_count);
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    ACT_UPDATE, ACT_DELETE: begin
                        n_lo    = '0;
                        n_hip1  = r_count;
                        n_state = S_SRCH;
                    end
                    default: begin
                        n_res   = make_res(ST_DONE, '0, '0, '0, r_count);
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SRCH: begin
                if (r_lo >= r_hip1) begin
                    n_res   = make_res(ST_NOT_FOUND, '0, r_in.key, '0, r_count);
                    n_state = S_DONE;
                end else if (w_eq[w_mid]) begin
                    n_slot  = w_mid;
                    n_state = (r_in.action == ACT_DELETE) ? S_READ : S_EXEC;
                end else if (w_lt[w_mid]) begin
                    n_lo = CW'(w_mid) + CW'(1);
                end else begin
                    n_hip1 = CW'(w_mid);
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_in.action)
                    ACT_INSERT: begin
                        w_ctl.op = CELL_INS;
                        n_count  = r_count + CW'(1);
                        n_res    = make_res(ST_DONE, w_ins_pos, r_in.key, w_pay_in,
                                            r_count + CW'(1));
                    end
                    ACT_UPDATE: begin
                        w_ctl.op = CELL_UPD;
                        n_res    = make_res(ST_DONE, r_slot, r_in.key, w_pay_in, r_count);
                    end
                    ACT_DELETE: begin
                        w_ctl.op = CELL_DEL;
                        n_count  = r_count - CW'(1);
                        n_res    = make_res(ST_DONE, r_slot, r_in.key, w_rd,
                                            r_count - CW'(1));
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a word was taken");

    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_in.action == ACT_INSERT) |-> $onehot(w_ins))
        else $error("insert slot not unique");

    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((w_lt & w_eq) == '0))
        else $error("cell flags both less and equal");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_in.action == ACT_DELETE) |=>
        (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not drop the count");

endmodule

FILE: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted table: holds a record, compares it against the
// broadcast key and trades records with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7,
    parameter int PW  = 32
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [PW-1:0]       i_pay,
    input  logic [IW-1:0]       i_slot,
    input  logic [CW-1:0]       i_count,
    input  logic                i_below_gt,
    input  logic [KEY_BITS-1:0] i_below_key,
    input  logic [PW-1:0]       i_below_pay,
    input  logic [KEY_BITS-1:0] i_above_key,
    input  logic [PW-1:0]       i_above_pay,
    output logic [KEY_BITS-1:0] o_key,
    output logic [PW-1:0]       o_pay,
    output t_cell_flag          o_flag
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [PW-1:0]       r_pay, n_pay;
    logic                r_lt, r_eq, r_gt;
    logic                n_lt, n_eq, n_gt;
    logic                w_valid;
    logic                w_ins;

    assign w_valid = (CW'(IDX) < i_count);
    // new record lands where the neighbor below is not larger and this one is
    // larger or is the first empty slot
    assign w_ins   = !i_below_gt && (r_gt || (CW'(IDX) == i_count));

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        n_lt  = r_lt;
        n_eq  = r_eq;
        n_gt  = r_gt;
        case (i_ctl.op)
            CELL_CMP: begin
                n_lt = w_valid && (r_key < i_ctl.key);
                n_eq = w_valid && (r_key == i_ctl.key);
                n_gt = w_valid && (r_key > i_ctl.key);
            end
            CELL_INS: begin
                if (i_below_gt) begin
                    n_key = i_below_key;
                    n_pay = i_below_pay;
                end else if (w_ins) begin
                    n_key = i_ctl.key;
                    n_pay = i_pay;
                end
            end
            CELL_UPD: begin
                if (IW'(IDX) == i_slot) begin
                    n_pay = i_pay;
                end
            end
            CELL_DEL: begin
                if (w_valid && (IW'(IDX) >= i_slot)) begin
                    n_key = i_above_key;
                    n_pay = i_above_pay;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
        r_lt  <= n_lt;
        r_eq  <= n_eq;
        r_gt  <= n_gt;
    end

    assign o_key      = r_key;
    assign o_pay      = r_pay;
    assign o_flag.lt  = r_lt;
    assign o_flag.eq  = r_eq;
    assign o_flag.gt  = r_gt;
    assign o_flag.ins = w_ins;

endmodule
